@@ rtl/cdip_pkg.sv @@
`timescale 1ns / 1ps
package cdip_pkg;

	localparam int LINES      = 256;
	localparam int LINE_W     = 8;
	localparam int LEVELS     = 16;
	localparam int LVL_W      = 4;
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

	localparam logic [13:0] ELAPSED_CAP  = 14'd8192;
	localparam logic [14:0] INTERVAL_CAP = 15'd16384;
	localparam logic [15:0] OCC_CAP      = 16'd65535;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_HIT  = 2'd1,
		MODE_MISS = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_LET_OVF   = 2'd0,
		CFG_MIN_COUNT = 2'd1,
		CFG_LIMIT     = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [LINE_W-1:0] line;
	} item_t;

	typedef struct packed {
		logic [14:0] decay_limit;
		logic [13:0] elapsed;
		logic [3:0]  access_count;
		logic        wrong_bit;
		logic        access_overflow;
	} result_t;

	typedef struct packed {
		logic [13:0] elapsed;
		logic [3:0]  count;
		logic [13:0] gap;
		logic [14:0] decay;
		logic        onoff;
		logic        wrong;
		logic        ovf;
	} line_rec_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DECIDE,
		ST_HIT_MAX,
		ST_MISS_IV,
		ST_PROP1,
		ST_HALVE,
		ST_PROP2,
		ST_MISS_MAX,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic tick;
		logic hit_top;
		logic hit;
		logic miss_clear;
		logic iv_update;
		logic prop_step;
		logic occ_commit;
		logic halve_step;
		logic set_idx_next;
		logic take_max;
		logic write;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  ovf;
		logic  hit_top;
		logic  idx_zero;
		logic  halve;
	} status_t;

endpackage

@@ rtl/cache_decay_interval_predictor.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// item      start / busy             item (mode, line)
// result    done, one cycle          result (decay_limit .. access_overflow)
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A tick updates the line; a hit below the top also takes a maximum; a miss without
// overflow adds the interval update, up to 15 steps of maxima propagation, and at
// the limit an occurrence halving and a second 15-step pass, one entry per cycle.
// The line state memory and its valid bits make reset immediate; no clearing pass.
// done is a single-cycle strobe; the receiver cannot stall it.
module cache_decay_interval_predictor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cdip_pkg::item_t   item,
	output logic              done,
	output cdip_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	cdip_pkg::cmd_t    cmd;
	cdip_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	cdip_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	cdip_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.done      (done)
	);

endmodule

@@ rtl/cdip_ctrl.sv @@
`timescale 1ns / 1ps
module cdip_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cdip_pkg::status_t sts,
	output cdip_pkg::cmd_t    cmd,
	output logic              busy
);

	cdip_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdip_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != cdip_pkg::ST_IDLE);
		case (state_q)
			cdip_pkg::ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d = cdip_pkg::ST_READ;
				end
			end
			cdip_pkg::ST_READ: begin
				cmd.load = 1'b1;
				state_d = cdip_pkg::ST_DECIDE;
			end
			cdip_pkg::ST_DECIDE: begin
				state_d = cdip_pkg::ST_WRITE;
				case (sts.mode)
					cdip_pkg::MODE_TICK: cmd.tick = 1'b1;
					cdip_pkg::MODE_HIT: begin
						if (sts.hit_top) begin
							cmd.hit_top = 1'b1;
						end else begin
							cmd.hit = 1'b1;
							state_d = cdip_pkg::ST_HIT_MAX;
						end
					end
					cdip_pkg::MODE_MISS: begin
						if (sts.ovf) begin
							cmd.miss_clear = 1'b1;
						end else begin
							state_d = cdip_pkg::ST_MISS_IV;
						end
					end
					default: state_d = cdip_pkg::ST_WRITE;
				endcase
			end
			cdip_pkg::ST_HIT_MAX: begin
				cmd.take_max = 1'b1;
				state_d = cdip_pkg::ST_WRITE;
			end
			cdip_pkg::ST_MISS_IV: begin
				cmd.iv_update = 1'b1;
				state_d = cdip_pkg::ST_PROP1;
			end
			cdip_pkg::ST_PROP1: begin
				if (!sts.idx_zero) begin
					cmd.prop_step = 1'b1;
				end else if (sts.halve) begin
					cmd.occ_commit = 1'b1;
					state_d = cdip_pkg::ST_HALVE;
				end else begin
					cmd.occ_commit = 1'b1;
					cmd.set_idx_next = 1'b1;
					state_d = cdip_pkg::ST_MISS_MAX;
				end
			end
			cdip_pkg::ST_HALVE: begin
				cmd.halve_step = 1'b1;
				state_d = cdip_pkg::ST_PROP2;
			end
			cdip_pkg::ST_PROP2: begin
				if (!sts.idx_zero) begin
					cmd.prop_step = 1'b1;
				end else begin
					cmd.set_idx_next = 1'b1;
					state_d = cdip_pkg::ST_MISS_MAX;
				end
			end
			cdip_pkg::ST_MISS_MAX: begin
				cmd.take_max = 1'b1;
				cmd.miss_clear = 1'b1;
				state_d = cdip_pkg::ST_WRITE;
			end
			cdip_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
				state_d = cdip_pkg::ST_IDLE;
			end
			default: state_d = cdip_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/cdip_dp.sv @@
`timescale 1ns / 1ps
module cdip_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cdip_pkg::item_t   item,
	input  cdip_pkg::cmd_t    cmd,
	output cdip_pkg::status_t sts,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output cdip_pkg::result_t result,
	output logic              done
);

	cdip_pkg::line_rec_t line_mem [cdip_pkg::LINES];
	cdip_pkg::line_rec_t rd_q;
	logic [cdip_pkg::LINES-1:0] valid_q;
	logic                       rd_valid_q;

	logic [14:0] iv_q  [cdip_pkg::LEVELS];
	logic [14:0] mx_q  [cdip_pkg::LEVELS];
	logic [15:0] occ_q [cdip_pkg::LEVELS];

	logic                        let_ovf_q;
	logic [15:0]                 min_count_q;
	logic [15:0]                 limit_q;
	cdip_pkg::mode_t             mode_q;
	logic [cdip_pkg::LINE_W-1:0] line_q;
	cdip_pkg::line_rec_t         rec_q;
	logic [cdip_pkg::LVL_W-1:0]  idx_q;
	logic                        halve_q;
	cdip_pkg::result_t           result_q;
	logic                        done_q;

	logic [14:0] iv_cur;
	logic [15:0] occ_cur;
	logic [15:0] occ_lvl;
	logic [15:0] iv_dbl;
	logic [14:0] iv_new;
	logic [15:0] occ_new;
	logic        grow;
	logic        shrink;
	logic [3:0]  cnt_hit;
	logic [cdip_pkg::LVL_W-1:0] idx_hit;
	logic [cdip_pkg::LVL_W-1:0] idx_next;
	logic [14:0] prop_val;

	assign iv_cur  = iv_q[idx_q];
	assign occ_cur = occ_q[idx_q];
	assign occ_lvl = occ_q[rec_q.count];
	assign iv_dbl  = {iv_cur, 1'b0};
	assign grow    = {1'b0, rec_q.gap} > iv_cur;
	assign shrink  = {rec_q.gap, 1'b0} < iv_cur;
	assign occ_new = (occ_lvl < cdip_pkg::OCC_CAP) ? occ_lvl + 16'd1 : occ_lvl;
	assign cnt_hit = (rec_q.count < cdip_pkg::LVL_TOP) ? rec_q.count + 4'd1 : rec_q.count;
	assign idx_hit = (cnt_hit < cdip_pkg::LVL_TOP) ? cnt_hit + 4'd1 : cdip_pkg::LVL_TOP;
	assign idx_next = (rec_q.count < cdip_pkg::LVL_TOP) ? rec_q.count + 4'd1
	                                                    : cdip_pkg::LVL_TOP;
	assign prop_val = (occ_cur > min_count_q && iv_cur >= mx_q[idx_q]) ? iv_cur : mx_q[idx_q];

	always_comb begin
		if (grow) begin
			iv_new = (iv_dbl > {1'b0, cdip_pkg::INTERVAL_CAP}) ? cdip_pkg::INTERVAL_CAP
			                                                   : iv_dbl[14:0];
		end else if (iv_cur > 15'd1) begin
			iv_new = iv_cur >> 1;
		end else begin
			iv_new = 15'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q <= line_mem[item.line];
		end
		if (cmd.write) begin
			line_mem[line_q] <= rec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				rd_valid_q <= valid_q[item.line];
			end
			if (cmd.write) begin
				valid_q[line_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			let_ovf_q   <= 1'b0;
			min_count_q <= 16'd8;
			limit_q     <= 16'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				cdip_pkg::CFG_LET_OVF:   let_ovf_q   <= cfg_data[0];
				cdip_pkg::CFG_MIN_COUNT: min_count_q <= cfg_data;
				cdip_pkg::CFG_LIMIT:     limit_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < cdip_pkg::LEVELS; k++) begin
				iv_q[k]  <= 15'd1;
				mx_q[k]  <= 15'd1;
				occ_q[k] <= 16'd0;
			end
			idx_q   <= '0;
			halve_q <= 1'b0;
		end else begin
			if (cmd.iv_update) begin
				if (grow || shrink) begin
					iv_q[idx_q] <= iv_new;
				end
				halve_q <= (occ_new >= limit_q);
				if (!(grow || shrink)) begin
					idx_q <= '0;
				end
			end
			if (cmd.prop_step) begin
				mx_q[idx_q - 1'b1] <= prop_val;
				idx_q <= idx_q - 1'b1;
			end
			if (cmd.occ_commit) begin
				occ_q[rec_q.count] <= occ_new;
			end
			if (cmd.halve_step) begin
				for (int k = 0; k < cdip_pkg::LEVELS; k++) begin
					occ_q[k] <= occ_q[k] >> 1;
				end
				idx_q <= cdip_pkg::LVL_TOP;
			end
			if (cmd.hit) begin
				idx_q <= idx_hit;
			end
			if (cmd.set_idx_next) begin
				idx_q <= idx_next;
			end
			if (cmd.load && rd_valid_q && mode_q == cdip_pkg::MODE_MISS) begin
				idx_q <= rd_q.count;
			end else if (cmd.load && mode_q == cdip_pkg::MODE_MISS) begin
				idx_q <= '0;
			end
			if (cmd.accept) begin
				halve_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= cdip_pkg::mode_t'(item.mode);
			line_q <= item.line;
		end
		if (cmd.load) begin
			rec_q <= rd_valid_q ? rd_q : '0;
		end
		if (cmd.tick && rec_q.elapsed < cdip_pkg::ELAPSED_CAP && !rec_q.ovf) begin
			rec_q.elapsed <= rec_q.elapsed + 14'd1;
		end
		if (cmd.hit_top) begin
			rec_q.ovf   <= 1'b1;
			rec_q.wrong <= 1'b1;
		end
		if (cmd.hit) begin
			rec_q.count <= cnt_hit;
			if (rec_q.elapsed > rec_q.gap) begin
				rec_q.gap <= rec_q.elapsed;
			end
			if (!rec_q.onoff) begin
				rec_q.wrong <= 1'b1;
			end
		end
		if (cmd.take_max) begin
			rec_q.decay <= mx_q[idx_q];
		end
		if (cmd.miss_clear) begin
			rec_q.onoff   <= 1'b1;
			rec_q.wrong   <= 1'b0;
			rec_q.count   <= 4'd1;
			rec_q.gap     <= '0;
			rec_q.elapsed <= '0;
			rec_q.ovf     <= 1'b0;
		end
		if (cmd.write) begin
			result_q.decay_limit     <= rec_q.decay;
			result_q.elapsed         <= rec_q.elapsed;
			result_q.access_count    <= rec_q.count;
			result_q.wrong_bit       <= rec_q.wrong;
			result_q.access_overflow <= rec_q.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.write;
		end
	end

	assign sts.mode     = mode_q;
	assign sts.ovf      = rec_q.ovf;
	assign sts.hit_top  = !let_ovf_q && rec_q.count >= cdip_pkg::LVL_TOP;
	assign sts.idx_zero = (idx_q == '0);
	assign sts.halve    = halve_q;
	assign result = result_q;
	assign done   = done_q;

endmodule

@@ rtl/cdip_checker.sv @@
`timescale 1ns / 1ps
module cdip_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input cdip_pkg::result_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an item was accepted");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobe right after accepting an item");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.decay_limit <= 15'd16384 && result.elapsed <= 14'd8192))
		else $error("result field out of range");

endmodule

bind cache_decay_interval_predictor cdip_checker u_cdip_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import cdip_pkg::*;

	typedef struct packed {
		logic    pinned;
		result_t val;
	} pin_t;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] line;
		logic       pinned;
		result_t    val;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	item_t       item = '0;
	logic        done;
	result_t     result;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	cache_decay_interval_predictor dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Model state of the predictor.
	logic        m_let_ovf;
	logic [15:0] m_min_count;
	logic [15:0] m_count_limit;
	logic [13:0] ln_elapsed [LINES];
	logic [3:0]  ln_count [LINES];
	logic [13:0] ln_gap [LINES];
	logic [14:0] ln_decay [LINES];
	logic        ln_onoff [LINES];
	logic        ln_wrong [LINES];
	logic        ln_ovf [LINES];
	logic [14:0] iv_tab [LEVELS];
	logic [14:0] max_tab [LEVELS];
	logic [15:0] occ_tab [LEVELS];

	result_t exp_results [$];
	pin_t    pin_q [$];
	int      errors = 0;
	bit      idle_on = 1;

	function automatic logic [14:0] max_next(logic [3:0] c);
		int k;
		k = int'(c) + 1;
		if (k > LEVELS - 1)
			k = LEVELS - 1;
		return max_tab[k];
	endfunction

	function automatic void spread_maxima(int from);
		int i;
		if (from > LEVELS - 1)
			from = LEVELS - 1;
		for (i = from; i > 0; i--) begin
			if (occ_tab[i] > m_min_count && iv_tab[i] >= max_tab[i])
				max_tab[i-1] = iv_tab[i];
			else
				max_tab[i-1] = max_tab[i];
		end
	endfunction

	function automatic result_t predict_line(item_t it);
		int ln;
		int c;
		logic [15:0] dbl;
		result_t r;
		ln = it.line;
		case (it.mode)
			MODE_TICK: begin
				if (ln_elapsed[ln] < ELAPSED_CAP && !ln_ovf[ln])
					ln_elapsed[ln]++;
			end
			MODE_HIT: begin
				if (!m_let_ovf && ln_count[ln] >= LVL_TOP) begin
					ln_ovf[ln] = 1;
					ln_wrong[ln] = 1;
				end else begin
					if (ln_count[ln] < LVL_TOP)
						ln_count[ln]++;
					if (ln_elapsed[ln] > ln_gap[ln])
						ln_gap[ln] = ln_elapsed[ln];
					if (!ln_onoff[ln])
						ln_wrong[ln] = 1;
					ln_decay[ln] = max_next(ln_count[ln]);
				end
			end
			MODE_MISS: begin
				if (!ln_ovf[ln]) begin
					c = ln_count[ln];
					if ({1'b0, ln_gap[ln]} > iv_tab[c]) begin
						dbl = {iv_tab[c], 1'b0};
						iv_tab[c] = dbl > INTERVAL_CAP ? INTERVAL_CAP : dbl[14:0];
						spread_maxima(c);
					end else if ({ln_gap[ln], 1'b0} < iv_tab[c]) begin
						iv_tab[c] = iv_tab[c] > 1 ? iv_tab[c] >> 1 : 15'd1;
						spread_maxima(c);
					end
					if (occ_tab[c] < OCC_CAP)
						occ_tab[c]++;
					if (occ_tab[c] >= m_count_limit) begin
						for (int k = 0; k < LEVELS; k++)
							occ_tab[k] = occ_tab[k] >> 1;
						spread_maxima(LEVELS - 1);
					end
					ln_decay[ln] = max_next(ln_count[ln]);
				end
				ln_onoff[ln] = 1;
				ln_wrong[ln] = 0;
				ln_count[ln] = 1;
				ln_gap[ln] = 0;
				ln_elapsed[ln] = 0;
				ln_ovf[ln] = 0;
			end
			default: ;
		endcase
		r.decay_limit = ln_decay[ln];
		r.elapsed = ln_elapsed[ln];
		r.access_count = ln_count[ln];
		r.wrong_bit = ln_wrong[ln];
		r.access_overflow = ln_ovf[ln];
		return r;
	endfunction

	initial begin
		m_let_ovf = 0;
		m_min_count = 16'd8;
		m_count_limit = 16'd1024;
		for (int i = 0; i < LINES; i++) begin
			ln_elapsed[i] = 0; ln_count[i] = 0; ln_gap[i] = 0; ln_decay[i] = 0;
			ln_onoff[i] = 0; ln_wrong[i] = 0; ln_ovf[i] = 0;
		end
		for (int i = 0; i < LEVELS; i++) begin
			iv_tab[i] = 1; max_tab[i] = 1; occ_tab[i] = 0;
		end
	end

	always @(posedge clk) begin
		result_t r;
		pin_t p;
		if (done) begin
			if (exp_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", result);
			end else begin
				r = exp_results.pop_front();
				if (result.decay_limit !== r.decay_limit || result.elapsed !== r.elapsed ||
						result.access_count !== r.access_count ||
						result.wrong_bit !== r.wrong_bit ||
						result.access_overflow !== r.access_overflow) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected limit %0d elapsed %0d count %0d wrong %0b ovf %0b, got limit %0d elapsed %0d count %0d wrong %0b ovf %0b",
							r.decay_limit, r.elapsed, r.access_count, r.wrong_bit,
							r.access_overflow, result.decay_limit, result.elapsed,
							result.access_count, result.wrong_bit, result.access_overflow);
				end
			end
		end
		if (arst_n && start && !busy) begin
			r = predict_line(item);
			p = pin_q.pop_front();
			if (p.pinned)
				r = p.val;
			exp_results.push_back(r);
		end
	end

	task automatic send_item(logic [1:0] m, logic [7:0] l, logic pinned, result_t v);
		pin_t p;
		p.pinned = pinned;
		p.val = v;
		pin_q.push_back(p);
		item <= '{mode: m, line: l};
		start <= 1;
		do @(posedge clk); while (busy);
		if (idle_on && $urandom_range(99) < 28) begin
			start <= 0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		start <= 0;
		@(posedge clk);
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CFG_LET_OVF:   m_let_ovf = val[0];
			CFG_MIN_COUNT: m_min_count = val;
			CFG_LIMIT:     m_count_limit = val;
			default: ;
		endcase
	endtask

	task automatic random_phase(int n, int span);
		logic [1:0] m;
		logic [7:0] l;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			m = r < 40 ? MODE_TICK : r < 72 ? MODE_HIT : r < 95 ? MODE_MISS : MODE_NONE;
			l = $urandom_range(99) < 85 ? 8'($urandom_range(span)) : 8'($urandom);
			send_item(m, l, 0, '0);
		end
	endtask

	row_t rows [] = '{
		'{MODE_TICK, 8'd0,   1, '{15'd0, 14'd1, 4'd0, 1'b0, 1'b0}},
		'{MODE_HIT,  8'd1,   1, '{15'd1, 14'd0, 4'd1, 1'b1, 1'b0}},
		'{MODE_MISS, 8'd2,   1, '{15'd1, 14'd0, 4'd1, 1'b0, 1'b0}},
		'{MODE_NONE, 8'd3,   1, '{15'd0, 14'd0, 4'd0, 1'b0, 1'b0}},
		'{MODE_TICK, 8'd255, 1, '{15'd0, 14'd1, 4'd0, 1'b0, 1'b0}},
		'{MODE_MISS, 8'd255, 0, '0},
		'{MODE_TICK, 8'd255, 0, '0},
		'{MODE_TICK, 8'd255, 0, '0},
		'{MODE_HIT,  8'd255, 0, '0},
		'{MODE_TICK, 8'd255, 0, '0},
		'{MODE_MISS, 8'd255, 0, '0},
		'{MODE_MISS, 8'd2,   0, '0},
		'{MODE_HIT,  8'd2,   0, '0},
		'{MODE_MISS, 8'd2,   0, '0},
		'{MODE_NONE, 8'd255, 0, '0},
		'{MODE_HIT,  8'd170, 0, '0},
		'{MODE_TICK, 8'd85,  0, '0}
	};

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i])
			send_item(rows[i].mode, rows[i].line, rows[i].pinned, rows[i].val);
		// Raise one line's access count with ten hits among ticks, then tick and miss it.
		send_item(MODE_MISS, 8'd4, 0, '0);
		for (int i = 0; i < 16; i++)
			send_item(i % 3 == 0 ? MODE_TICK : MODE_HIT, 8'd4, 0, '0);
		send_item(MODE_TICK, 8'd4, 0, '0);
		send_item(MODE_MISS, 8'd4, 0, '0);

		random_phase(130, 7);
		write_reg(CFG_LET_OVF, 16'd1);
		write_reg(CFG_MIN_COUNT, 16'd0);
		write_reg(CFG_LIMIT, 16'd2);
		random_phase(130, 7);
		write_reg(CFG_LET_OVF, 16'd0);
		write_reg(CFG_MIN_COUNT, 16'hFFFF);
		write_reg(CFG_LIMIT, 16'hFFFF);
		idle_on = 0;
		random_phase(140, 15);
		idle_on = 1;
		write_reg(CFG_MIN_COUNT, 16'd2);
		write_reg(CFG_LIMIT, 16'd12);
		random_phase(130, 3);
		write_reg(CFG_LET_OVF, 16'd1);
		write_reg(CFG_MIN_COUNT, 16'($urandom_range(4)));
		write_reg(CFG_LIMIT, 16'($urandom_range(40, 2)));
		random_phase(130, 31);
		start <= 0;
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end
endmodule

@@ cache_decay_interval_predictor.f @@
rtl/cdip_pkg.sv
rtl/cdip_ctrl.sv
rtl/cdip_dp.sv
rtl/cache_decay_interval_predictor.sv
rtl/cdip_checker.sv
sim/testbench.sv
